### hw/rtl/mrr_pkg.sv
// shared types and constants for the rational-to-residue reduction core
package mrr_pkg;

   localparam int unsigned WordW = 64;
   localparam int unsigned PrimeW = 63;
   localparam int unsigned CntW = 7;
   localparam int unsigned DataWidthDefault = 64;
   localparam logic [PrimeW-1:0] PrimeReset = 63'd9223372036854775783;

   typedef struct packed {
      logic [WordW-1:0] numerator;
      logic [WordW-1:0] denominator;
      logic             has_denominator;
      logic             unsigned_mode;
   } req_type;

   typedef struct packed {
      logic [WordW-1:0] residue;
      logic             error;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_NUM_RAW,
      OP_DIV_NUM,
      OP_SET_NUM_FIX,
      OP_SET_A_DEN_RAW,
      OP_DIV_DEN,
      OP_SET_A_REM,
      OP_EU_INIT,
      OP_DIV_A,
      OP_EU_UPD,
      OP_DIV_C1,
      OP_DIV_NUMR,
      OP_DIV_STEP,
      OP_MUL_INIT,
      OP_MUL_STEP,
      OP_RES_NUM,
      OP_RES_MUL,
      OP_RES_ERR
   } op_type;

   typedef struct packed {
      logic p_zero;
      logic p_one;
      logic uns;
      logic has;
      logic den_neg;
      logic a_le1;
      logic b_zero;
      logic cnt_last;
   } status_type;

endpackage

### hw/rtl/mrr_dp.sv
// datapath: prime register, shared restoring divider, euclid coefficients, modular multiplier
module mrr_dp #(
   parameter int unsigned DATA_WIDTH = mrr_pkg::DataWidthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mrr_pkg::op_type             op,
   output mrr_pkg::status_type         status,
   input  mrr_pkg::req_type            req_data,
   input  logic                        csr_write,
   input  logic [mrr_pkg::PrimeW-1:0]  csr_data,
   output mrr_pkg::rsp_type            rsp_data
);
   import mrr_pkg::*;

   logic [PrimeW-1:0]     prime_ff;
   logic [DATA_WIDTH-1:0] num_w_ff;
   logic [DATA_WIDTH-1:0] den_w_ff;
   logic                  has_ff;
   logic                  uns_ff;
   logic [WordW-1:0]      num_ff;
   logic [WordW-1:0]      a_ff;
   logic [WordW-1:0]      b_ff;
   logic [WordW-1:0]      c0_ff;
   logic [WordW-1:0]      c1_ff;
   logic [WordW-1:0]      acc_ff;
   logic [WordW-1:0]      rem_ff;
   logic [WordW-1:0]      dvd_ff;
   logic [WordW-1:0]      x_ff;
   logic [WordW-1:0]      y_ff;
   logic [WordW-1:0]      r_ff;
   logic [CntW-1:0]       cnt_ff;
   rsp_type               res_ff;

   logic [WordW-1:0] p64;
   logic             num_neg;
   logic [WordW-1:0] num_mag;
   logic [WordW:0]   rem_sh;
   logic [WordW:0]   rem_sub;
   logic             ge;
   logic [WordW-1:0] rem_next;
   logic [WordW-1:0] acc_next;
   logic [WordW-1:0] num_fix;
   logic [WordW-1:0] c1_fix;
   logic [WordW:0]   pm;
   logic [WordW:0]   r2;
   logic [WordW:0]   r2s;
   logic [WordW:0]   r3;
   logic [WordW:0]   r4;

   assign p64 = {1'b0, prime_ff};
   assign pm = {1'b0, p64};
   assign num_neg = num_w_ff[DATA_WIDTH-1];
   assign num_mag = num_neg ? (WordW'(~num_w_ff) + 64'd1) : WordW'(num_w_ff);

   // one quotient bit per cycle, quotient times c0 accumulated msb first
   assign rem_sh = {rem_ff, dvd_ff[WordW-1]};
   assign rem_sub = rem_sh - {1'b0, b_ff};
   assign ge = rem_sh >= {1'b0, b_ff};
   assign rem_next = ge ? rem_sub[WordW-1:0] : rem_sh[WordW-1:0];
   assign acc_next = {acc_ff[WordW-2:0], 1'b0} + (ge ? c0_ff : '0);

   assign num_fix = (num_neg && (rem_ff != '0)) ? (p64 - rem_ff) : rem_ff;
   assign c1_fix = c1_ff[WordW-1] ? (c1_ff + p64) : c1_ff;

   // double and add, msb of y first
   assign r2 = {r_ff, 1'b0};
   assign r2s = (r2 >= pm) ? (r2 - pm) : r2;
   assign r3 = r2s + {1'b0, (y_ff[WordW-1] ? x_ff : '0)};
   assign r4 = (r3 >= pm) ? (r3 - pm) : r3;

   always_comb begin
      status.p_zero = prime_ff == '0;
      status.p_one = prime_ff == PrimeW'(1);
      status.uns = uns_ff;
      status.has = has_ff;
      status.den_neg = den_w_ff[DATA_WIDTH-1];
      status.a_le1 = a_ff <= WordW'(1);
      status.b_zero = b_ff == '0;
      status.cnt_last = cnt_ff == CntW'(1);
   end

   assign rsp_data = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= PrimeReset;
      end else if (csr_write) begin
         prime_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            num_w_ff <= req_data.numerator[DATA_WIDTH-1:0];
            den_w_ff <= req_data.denominator[DATA_WIDTH-1:0];
            has_ff <= req_data.has_denominator;
            uns_ff <= req_data.unsigned_mode;
         end
         OP_SET_NUM_RAW: begin
            num_ff <= WordW'(num_w_ff);
         end
         OP_DIV_NUM: begin
            dvd_ff <= num_mag;
            b_ff <= p64;
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_SET_NUM_FIX: begin
            num_ff <= num_fix;
         end
         OP_SET_A_DEN_RAW: begin
            a_ff <= WordW'(den_w_ff);
         end
         OP_DIV_DEN: begin
            dvd_ff <= WordW'(den_w_ff);
            b_ff <= p64;
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_SET_A_REM: begin
            a_ff <= rem_ff;
         end
         OP_EU_INIT: begin
            b_ff <= p64;
            c0_ff <= '0;
            c1_ff <= WordW'(1);
         end
         OP_DIV_A: begin
            dvd_ff <= a_ff;
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_EU_UPD: begin
            b_ff <= rem_ff;
            a_ff <= b_ff;
            c0_ff <= c1_ff - acc_ff;
            c1_ff <= c0_ff;
         end
         OP_DIV_C1: begin
            dvd_ff <= c1_fix;
            b_ff <= p64;
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_DIV_NUMR: begin
            y_ff <= rem_ff;
            dvd_ff <= num_ff;
            b_ff <= p64;
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_DIV_STEP: begin
            rem_ff <= rem_next;
            acc_ff <= acc_next;
            dvd_ff <= {dvd_ff[WordW-2:0], 1'b0};
            cnt_ff <= cnt_ff - CntW'(1);
         end
         OP_MUL_INIT: begin
            x_ff <= rem_ff;
            r_ff <= '0;
            cnt_ff <= CntW'(WordW);
         end
         OP_MUL_STEP: begin
            r_ff <= r4[WordW-1:0];
            y_ff <= {y_ff[WordW-2:0], 1'b0};
            cnt_ff <= cnt_ff - CntW'(1);
         end
         OP_RES_NUM: begin
            res_ff.residue <= num_ff;
            res_ff.error <= 1'b0;
         end
         OP_RES_MUL: begin
            res_ff.residue <= r_ff;
            res_ff.error <= 1'b0;
         end
         OP_RES_ERR: begin
            res_ff.residue <= '0;
            res_ff.error <= 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/mrr_ctrl.sv
// controller state machine sequencing reduction, euclid steps and modular multiply
module mrr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  mrr_pkg::status_type status,
   output mrr_pkg::op_type     op
);
   import mrr_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE   = 18'b000000000000000001,
      ST_CHECK  = 18'b000000000000000010,
      ST_NDIV   = 18'b000000000000000100,
      ST_NFIX   = 18'b000000000000001000,
      ST_DEN    = 18'b000000000000010000,
      ST_DDIV   = 18'b000000000000100000,
      ST_DREM   = 18'b000000000001000000,
      ST_EUINIT = 18'b000000000010000000,
      ST_EUTEST = 18'b000000000100000000,
      ST_EUDIV  = 18'b000000001000000000,
      ST_EUUPD  = 18'b000000010000000000,
      ST_INV    = 18'b000000100000000000,
      ST_IDIV   = 18'b000001000000000000,
      ST_NRST   = 18'b000010000000000000,
      ST_NRDIV  = 18'b000100000000000000,
      ST_MULI   = 18'b001000000000000000,
      ST_MUL    = 18'b010000000000000000,
      ST_DONE   = 18'b100000000000000000
   } state_type;

   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_MUL,
      KIND_ERR
   } kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.p_zero) begin
               kind_in = KIND_ERR;
               state_in = ST_DONE;
            end else if (status.uns) begin
               op = OP_SET_NUM_RAW;
               if (status.has) begin
                  state_in = ST_DEN;
               end else begin
                  kind_in = KIND_NUM;
                  state_in = ST_DONE;
               end
            end else begin
               op = OP_DIV_NUM;
               state_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_NFIX;
         end
         ST_NFIX: begin
            op = OP_SET_NUM_FIX;
            if (status.has) begin
               state_in = ST_DEN;
            end else begin
               kind_in = KIND_NUM;
               state_in = ST_DONE;
            end
         end
         ST_DEN: begin
            priority if (status.uns) begin
               op = OP_SET_A_DEN_RAW;
               state_in = ST_EUINIT;
            end else if (status.den_neg) begin
               kind_in = KIND_ERR;
               state_in = ST_DONE;
            end else begin
               op = OP_DIV_DEN;
               state_in = ST_DDIV;
            end
         end
         ST_DDIV: begin
            op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_DREM;
         end
         ST_DREM: begin
            op = OP_SET_A_REM;
            state_in = ST_EUINIT;
         end
         ST_EUINIT: begin
            op = OP_EU_INIT;
            state_in = ST_EUTEST;
         end
         ST_EUTEST: begin
            priority if (status.p_one || status.a_le1) begin
               state_in = ST_INV;
            end else if (status.b_zero) begin
               kind_in = KIND_ERR;
               state_in = ST_DONE;
            end else begin
               op = OP_DIV_A;
               state_in = ST_EUDIV;
            end
         end
         ST_EUDIV: begin
            op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_EUUPD;
         end
         ST_EUUPD: begin
            op = OP_EU_UPD;
            state_in = ST_EUTEST;
         end
         ST_INV: begin
            op = OP_DIV_C1;
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_NRST;
         end
         ST_NRST: begin
            op = OP_DIV_NUMR;
            state_in = ST_NRDIV;
         end
         ST_NRDIV: begin
            op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_MULI;
         end
         ST_MULI: begin
            op = OP_MUL_INIT;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            op = OP_MUL_STEP;
            if (status.cnt_last) begin
               kind_in = KIND_MUL;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               unique case (kind_ff)
                  KIND_NUM: op = OP_RES_NUM;
                  KIND_MUL: op = OP_RES_MUL;
                  KIND_ERR: op = OP_RES_ERR;
                  default:  op = OP_RES_ERR;
               endcase
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff <= KIND_ERR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/modular_rational_reduce_core.sv
// top level of the rational-to-residue reduction core
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  mrr_pkg::req_type
//   rsp_      out         rsp_valid/rsp_stall  mrr_pkg::rsp_type
//   csr_      in          csr_valid/csr_ready  63-bit prime
//
// one transaction at a time; unsigned without denominator needs no divide, otherwise
// the work is serial: the shared bit-serial divider runs one divide per euclid
// step (up to about 92), plus up to four reductions and a bit-serial multiply
// synchronous reset loads the default prime and empties the output register
// the output register frees the datapath; a new transaction is taken once the previous
// result is registered, and rsp_stall holds the finished result and keeps a later result waiting
module modular_rational_reduce_core #(
   parameter int unsigned DATA_WIDTH = mrr_pkg::DataWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mrr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mrr_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mrr_pkg::PrimeW-1:0] csr_data
);
   import mrr_pkg::*;

   op_type     op;
   status_type status;

   assign csr_ready = 1'b1;

   mrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .op        (op)
   );

   mrr_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
